// ===== hw/rtl/cpte_pkg.sv =====
package cpte_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TW        = FRAC_BITS + 1;
  localparam int CW        = 32;
  localparam int WW        = 24;
  localparam int DW        = WW + 2;
  localparam int NW        = CW + WW + 2;
  localparam int XW        = NW + 1;
  localparam int QB        = CW + 1;
  localparam int DIFW      = CW + 1;
  localparam int WDW       = DIFW + WW + 1;
  localparam int WPW       = WDW - FRAC_BITS;
  localparam int AW        = WPW + 1;
  localparam int BCW       = WPW + 2;
  localparam int HW        = BCW + 3;
  localparam int GW        = HW + 3;
  localparam int TAW       = TW + 1 + AW;
  localparam int THW       = TW + 1 + HW;
  localparam int PBW       = CW + TW + 1;
  localparam int PWW       = CW + WW + 1;
  localparam int NREG      = 7;
  localparam int PAW       = $clog2(NREG * 4);

  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] WEIGHT_RESET = WW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] S_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] S_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_START_X,
    REG_START_Y,
    REG_CTRL_X,
    REG_CTRL_Y,
    REG_END_X,
    REG_END_Y,
    REG_CONIC_WEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [1:0]         lane;
    logic      [DW-1:0]      den;
    logic      [1:0][CW-1:0] tan;
    logic                    tsat;
  } div_item_t;

  typedef struct packed {
    logic signed [CW-1:0] v;
    logic                 sat;
  } clip_t;

  function automatic clip_t clip_gw(input logic signed [GW-1:0] v);
    clip_t r;
    r.sat = !((&v[GW-1:CW-1]) || !(|v[GW-1:CW-1]));
    r.v   = r.sat ? (v[GW-1] ? S_MIN : S_MAX) : v[CW-1:0];
    return r;
  endfunction

  function automatic clip_t quo_clip(input logic [QB-1:0] q, input logic neg,
                                     input logic ovf);
    clip_t r;
    logic  big;
    big = ovf | q[QB-1];
    if (neg) begin
      r.sat = big | (q[CW-1] & (|q[CW-2:0]));
      r.v   = r.sat ? S_MIN : (~q[CW-1:0] + CW'(1));
    end else begin
      r.sat = big | q[CW-1];
      r.v   = r.sat ? S_MAX : q[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cpte_if.sv =====
interface cpte_in_if import cpte_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [TW-1:0] t_param;

  modport source (output valid, output t_param, input ready);
  modport sink (input valid, input t_param, output ready);
endinterface

interface cpte_out_if import cpte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] tangent_dx;
  logic signed [CW-1:0] tangent_dy;
  logic                 saturated;

  modport source (output valid, output point_x, output point_y, output tangent_dx,
                  output tangent_dy, output saturated, input ready);
  modport sink (input valid, input point_x, input point_y, input tangent_dx,
                input tangent_dy, input saturated, output ready);
endinterface

// ===== hw/rtl/cpte_front.sv =====
module cpte_front import cpte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TW-1:0]        t_in,
  input  logic signed [CW-1:0] p0 [2],
  input  logic signed [CW-1:0] p1 [2],
  input  logic signed [CW-1:0] p2 [2],
  input  logic [WW-1:0]        w,
  output logic                 out_valid,
  input  logic                 out_ready,
  output div_item_t            out_item
);

  localparam int NS = 6;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  logic signed [DIFW-1:0] d20 [2];
  logic signed [DIFW-1:0] dp [2];
  logic signed [WDW-1:0]  wd20_r [2];
  logic signed [WDW-1:0]  wdp_r [2];
  logic signed [WPW-1:0]  wp [2];
  logic signed [AW-1:0]   a [2];
  logic signed [BCW-1:0]  bc [2];

  logic [TW-1:0]     t0_r, t1_r, t2_r, t3_r;
  logic [TW-1:0]     u1;
  logic [2*TW-1:0]   tt1, tu1;
  logic [TW-1:0]     b1_1_r, b2_1_r;
  logic [WW+TW-1:0]  wbp2;
  logic [WW-1:0]     wb1_2_r;
  logic [TW-1:0]     b0_2_r, b2_2_r;
  logic signed [TAW-1:0] ta_2_r [2];
  logic signed [PBW-1:0] nb0_3_r [2];
  logic signed [PWW-1:0] nw_3_r [2];
  logic signed [PBW-1:0] nb2_3_r [2];
  logic [DW-1:0]         den_3_r, den_4_r;
  logic signed [HW-1:0]  h_3_r [2];
  logic signed [NW-1:0]  n_4_r [2];
  logic signed [THW-1:0] th_4_r [2];
  logic [NW-1:0]         mag5 [2];
  logic [XW-1:0]         x5 [2];
  clip_t                 tc5 [2];
  div_item_t             item5, item5_r;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_item  = item5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      d20[k] = DIFW'(p2[k]) - DIFW'(p0[k]);
      dp[k]  = DIFW'(p1[k]) - DIFW'(p0[k]);
      wp[k]  = WPW'(wdp_r[k] >>> FRAC_BITS);
      a[k]   = AW'(wd20_r[k] >>> FRAC_BITS) - AW'(d20[k]);
      bc[k]  = BCW'(d20[k]) - (BCW'(wp[k]) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      wd20_r[k] <= $signed({1'b0, w}) * d20[k];
      wdp_r[k]  <= $signed({1'b0, w}) * dp[k];
    end
  end

  always_comb begin
    u1   = T_ONE - t0_r;
    tt1  = t0_r * t0_r;
    tu1  = t0_r * u1;
    wbp2 = w * b1_1_r;
  end

  always_comb begin
    item5.den  = den_4_r;
    item5.tsat = tc5[0].sat | tc5[1].sat;
    for (int k = 0; k < 2; k++) begin
      item5.lane[k].neg = n_4_r[k][NW-1];
      mag5[k] = n_4_r[k][NW-1] ? NW'(-n_4_r[k]) : NW'(n_4_r[k]);
      x5[k]   = XW'(mag5[k]) + XW'(den_4_r >> 1);
      item5.lane[k].ovf = x5[k][XW-1:QB] >= den_4_r;
      item5.lane[k].rem = x5[k][XW-1:QB];
      item5.lane[k].quo = x5[k][QB-1:0];
      tc5[k] = clip_gw(GW'(th_4_r[k] >>> FRAC_BITS) + GW'(wp[k]));
      item5.tan[k] = tc5[k].v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      t0_r <= (t_in > T_ONE) ? T_ONE : t_in;
    end
    if (rdy[1]) begin
      b1_1_r <= tu1[FRAC_BITS-1 +: TW];
      b2_1_r <= tt1[FRAC_BITS +: TW];
      t1_r   <= t0_r;
    end
    if (rdy[2]) begin
      wb1_2_r <= wbp2[FRAC_BITS +: WW];
      b0_2_r  <= T_ONE - b1_1_r - b2_1_r;
      b2_2_r  <= b2_1_r;
      t2_r    <= t1_r;
      for (int k = 0; k < 2; k++) begin
        ta_2_r[k] <= $signed({1'b0, t1_r}) * a[k];
      end
    end
    if (rdy[3]) begin
      den_3_r <= DW'(b0_2_r) + DW'(wb1_2_r) + DW'(b2_2_r);
      t3_r    <= t2_r;
      for (int k = 0; k < 2; k++) begin
        nb0_3_r[k] <= p0[k] * $signed({1'b0, b0_2_r});
        nw_3_r[k]  <= p1[k] * $signed({1'b0, wb1_2_r});
        nb2_3_r[k] <= p2[k] * $signed({1'b0, b2_2_r});
        h_3_r[k]   <= HW'(ta_2_r[k] >>> FRAC_BITS) + HW'(bc[k]);
      end
    end
    if (rdy[4]) begin
      den_4_r <= den_3_r;
      for (int k = 0; k < 2; k++) begin
        n_4_r[k]  <= NW'(nb0_3_r[k]) + NW'(nw_3_r[k]) + NW'(nb2_3_r[k]);
        th_4_r[k] <= $signed({1'b0, t3_r}) * h_3_r[k];
      end
    end
    if (rdy[5]) begin
      item5_r <= item5;
    end
  end

  a_basis_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (b1_1_r <= (T_ONE >> 1)) && (b2_1_r <= T_ONE))
    else $error("basis value out of range");

  a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> den_3_r >= DW'(T_ONE >> 1))
    else $error("denominator below one half");

endmodule

// ===== hw/rtl/cpte_div_cell.sv =====
module cpte_div_cell import cpte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output div_item_t out_item
);

  logic      v_r;
  div_item_t item_r;
  div_item_t item_nxt;
  logic [DW:0] r2 [2];
  logic        ge [2];

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_item  = item_r;

  always_comb begin
    item_nxt = in_item;
    for (int k = 0; k < 2; k++) begin
      r2[k] = {in_item.lane[k].rem, in_item.lane[k].quo[QB-1]};
      ge[k] = r2[k] >= {1'b0, in_item.den};
      item_nxt.lane[k].rem = ge[k] ? DW'(r2[k] - {1'b0, in_item.den}) : DW'(r2[k]);
      item_nxt.lane[k].quo = {in_item.lane[k].quo[QB-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item_r <= item_nxt;
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !item_r.lane[0].ovf |-> item_r.lane[0].rem < item_r.den)
    else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/conic_point_tangent_eval.sv =====
// Streams one item per clock cycle; back-pressure stalls only the stages holding items.
// From the accepting edge to a valid result an item passes six stages for
// the basis, products and sums, then 33 division cells, one quotient bit each,
// then the output register.
// Reset is synchronous and active low: it empties the pipeline and loads the
// control points with zero and the weight with one.
module conic_point_tangent_eval import cpte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cpte_in_if.sink           in_chan,
  cpte_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAW-1:0]    paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic signed [CW-1:0] p0_r [2];
  logic signed [CW-1:0] p1_r [2];
  logic signed [CW-1:0] p2_r [2];
  logic [WW-1:0]        w_r;
  reg_idx_t             idx;

  logic      cv [QB+1];
  logic      cr [QB+1];
  div_item_t ci [QB+1];

  logic                 ov_r;
  logic signed [CW-1:0] px_r, py_r, dx_r, dy_r;
  logic                 sat_r;
  clip_t                qx, qy;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PAW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r[0] <= '0;
      p0_r[1] <= '0;
      p1_r[0] <= '0;
      p1_r[1] <= '0;
      p2_r[0] <= '0;
      p2_r[1] <= '0;
      w_r     <= WEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_START_X:      p0_r[0] <= pwdata;
        REG_START_Y:      p0_r[1] <= pwdata;
        REG_CTRL_X:       p1_r[0] <= pwdata;
        REG_CTRL_Y:       p1_r[1] <= pwdata;
        REG_END_X:        p2_r[0] <= pwdata;
        REG_END_Y:        p2_r[1] <= pwdata;
        REG_CONIC_WEIGHT: w_r     <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_X:      prdata = p0_r[0];
      REG_START_Y:      prdata = p0_r[1];
      REG_CTRL_X:       prdata = p1_r[0];
      REG_CTRL_Y:       prdata = p1_r[1];
      REG_END_X:        prdata = p2_r[0];
      REG_END_Y:        prdata = p2_r[1];
      REG_CONIC_WEIGHT: prdata = 32'(w_r);
      default:          prdata = '0;
    endcase
  end

  cpte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .t_in      (in_chan.t_param),
    .p0        (p0_r),
    .p1        (p1_r),
    .p2        (p2_r),
    .w         (w_r),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_item  (ci[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cpte_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_item   (ci[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_item  (ci[g+1])
    );
  end

  assign cr[QB] = !ov_r || out_chan.ready;
  assign qx = quo_clip(ci[QB].lane[0].quo, ci[QB].lane[0].neg, ci[QB].lane[0].ovf);
  assign qy = quo_clip(ci[QB].lane[1].quo, ci[QB].lane[1].neg, ci[QB].lane[1].ovf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cr[QB]) begin
      ov_r <= cv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[QB] && cv[QB]) begin
      px_r  <= qx.v;
      py_r  <= qy.v;
      dx_r  <= ci[QB].tan[0];
      dy_r  <= ci[QB].tan[1];
      sat_r <= qx.sat | qy.sat | ci[QB].tsat;
    end
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.point_x    = px_r;
  assign out_chan.point_y    = py_r;
  assign out_chan.tangent_dx = dx_r;
  assign out_chan.tangent_dy = dy_r;
  assign out_chan.saturated  = sat_r;

  a_sat_has_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && sat_r |-> (px_r == S_MAX || px_r == S_MIN || py_r == S_MAX ||
                       py_r == S_MIN || dx_r == S_MAX || dx_r == S_MIN ||
                       dy_r == S_MAX || dy_r == S_MIN))
    else $error("saturation flagged without a clipped field");

endmodule
